@@ hdl/nend_pkg.sv @@
// ----------------------------------------------------------------------------
// nend_pkg - shared types and constants for the nested node deframer
// Item structs, event kinds, error codes and framing marker bytes.
// ----------------------------------------------------------------------------
package nend_pkg;

  localparam int MaxDepth = 16;       // hard ceiling on the nesting limit
  localparam int DepthW   = 5;
  localparam int HeaderLen = 4;       // magic bytes ahead of the root node

  localparam logic [7:0] MarkEsc   = 8'hFD;
  localparam logic [7:0] MarkOpen  = 8'hFE;
  localparam logic [7:0] MarkClose = 8'hFF;

  localparam logic [DepthW-1:0] DepthLimitRst = DepthW'(MaxDepth);

  typedef enum logic [2:0] {
    KIND_MAGIC    = 3'd0,
    KIND_OPEN     = 3'd1,
    KIND_DATA     = 3'd2,
    KIND_CLOSE    = 3'd3,
    KIND_CONSUMED = 3'd4,
    KIND_ERROR    = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NOSTART  = 3'd1,
    ERR_STRAY    = 3'd2,
    ERR_OVERFLOW = 3'd3,
    ERR_TRAILING = 3'd4,
    ERR_TRUNC    = 3'd5
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_file;
    logic       last_of_file;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        value;
    logic [DepthW-1:0] depth;
    logic [2:0]        error_code;
    logic              file_ok;
  } out_item_t;

endpackage

@@ hdl/nested_escaped_node_deframer.sv @@
// ----------------------------------------------------------------------------
// nested_escaped_node_deframer - streaming deframer for byte-stuffed nodes
// Passes a 4-byte magic header through, then tracks nested 0xFE/0xFF nodes
// with 0xFD escapes and emits one event item per input byte.
// ----------------------------------------------------------------------------
//  channel | ports                         | payload
//  --------+-------------------------------+--------------------------------
//  input   | in_valid / in_stall           | in_item  (nend_pkg::in_item_t)
//  result  | out_valid / out_stall         | out_item (nend_pkg::out_item_t)
//  config  | psel penable pwrite paddr ... | depth_limit at byte address 0
//
//  One item per cycle while in_stall is low; each result is registered.
//  The parser state update and the event decode sit in one stage between the
//  input port and the result register; a skid register behind it absorbs
//  one item while the result side stalls, and in_stall rises only when full.
//  Reset (rst_n low, synchronous) empties both result slots, restarts the
//  parser and sets depth_limit to 16.
// ----------------------------------------------------------------------------
module nested_escaped_node_deframer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  nend_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nend_pkg::out_item_t  out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int DW = nend_pkg::DepthW;

  // configuration
  logic [DW-1:0] depth_limit_r;
  logic [DW-1:0] lim;

  // parser state
  logic [2:0]     header_left_r, header_left_nxt;
  logic           escape_pending_r, escape_pending_nxt;
  logic           expect_id_r, expect_id_nxt;
  logic [DW-1:0]  nest_depth_r, nest_depth_nxt;
  logic           root_closed_r, root_closed_nxt;
  nend_pkg::err_t failed_r, failed_nxt;

  // result slots
  logic                out_valid_r, skid_valid_r;
  nend_pkg::out_item_t out_item_r, skid_item_r;
  nend_pkg::out_item_t res;

  logic in_fire, out_fire;

  assign pready   = 1'b1;
  assign prdata   = {{(32-DW){1'b0}}, depth_limit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_limit_r <= nend_pkg::DepthLimitRst;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      depth_limit_r <= pwdata[DW-1:0];
    end
  end

  always_comb begin
    if (depth_limit_r == '0) begin
      lim = DW'(1);
    end else if (depth_limit_r > DW'(nend_pkg::MaxDepth)) begin
      lim = DW'(nend_pkg::MaxDepth);
    end else begin
      lim = depth_limit_r;
    end
  end

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  // event decode and next parser state
  always_comb begin
    nend_pkg::kind_t kind;
    logic [7:0]      b;
    logic            ok;

    b    = in_item.data_byte;
    kind = nend_pkg::KIND_ERROR;
    ok   = 1'b0;
    res  = '0;

    if (in_item.first_of_file) begin
      header_left_nxt    = 3'(nend_pkg::HeaderLen);
      escape_pending_nxt = 1'b0;
      expect_id_nxt      = 1'b0;
      nest_depth_nxt     = '0;
      root_closed_nxt    = 1'b0;
      failed_nxt         = nend_pkg::ERR_NONE;
    end else begin
      header_left_nxt    = header_left_r;
      escape_pending_nxt = escape_pending_r;
      expect_id_nxt      = expect_id_r;
      nest_depth_nxt     = nest_depth_r;
      root_closed_nxt    = root_closed_r;
      failed_nxt         = failed_r;
    end

    if (failed_nxt != nend_pkg::ERR_NONE) begin
      res.depth = nest_depth_nxt;
    end else if (header_left_nxt != '0) begin
      kind            = nend_pkg::KIND_MAGIC;
      res.value       = b;
      header_left_nxt = header_left_nxt - 3'd1;
    end else if (root_closed_nxt) begin
      failed_nxt = nend_pkg::ERR_TRAILING;
      res.depth  = nest_depth_nxt;
    end else if (expect_id_nxt) begin
      // id byte is raw, markers included
      kind          = nend_pkg::KIND_OPEN;
      res.value     = b;
      res.depth     = nest_depth_nxt;
      expect_id_nxt = 1'b0;
    end else if (escape_pending_nxt) begin
      kind               = nend_pkg::KIND_DATA;
      res.value          = b;
      res.depth          = nest_depth_nxt;
      escape_pending_nxt = 1'b0;
    end else if (nest_depth_nxt == '0) begin
      if (b == nend_pkg::MarkOpen) begin
        nest_depth_nxt = DW'(1);
        expect_id_nxt  = 1'b1;
        kind           = nend_pkg::KIND_CONSUMED;
        res.depth      = DW'(1);
      end else begin
        failed_nxt = (b == nend_pkg::MarkClose) ? nend_pkg::ERR_STRAY
                                                : nend_pkg::ERR_NOSTART;
      end
    end else if (b == nend_pkg::MarkEsc) begin
      escape_pending_nxt = 1'b1;
      kind               = nend_pkg::KIND_CONSUMED;
      res.depth          = nest_depth_nxt;
    end else if (b == nend_pkg::MarkOpen) begin
      if (nest_depth_nxt >= lim) begin
        failed_nxt = nend_pkg::ERR_OVERFLOW;
        res.depth  = nest_depth_nxt;
      end else begin
        nest_depth_nxt = nest_depth_nxt + DW'(1);
        expect_id_nxt  = 1'b1;
        kind           = nend_pkg::KIND_CONSUMED;
        res.depth      = nest_depth_nxt;
      end
    end else if (b == nend_pkg::MarkClose) begin
      kind           = nend_pkg::KIND_CLOSE;
      res.depth      = nest_depth_nxt;
      nest_depth_nxt = nest_depth_nxt - DW'(1);
      if (nest_depth_nxt == '0) begin
        root_closed_nxt = 1'b1;
      end
    end else begin
      kind      = nend_pkg::KIND_DATA;
      res.value = b;
      res.depth = nest_depth_nxt;
    end

    if (in_item.last_of_file) begin
      // truncation replaces the byte's own event
      if (failed_nxt == nend_pkg::ERR_NONE && !root_closed_nxt) begin
        failed_nxt = nend_pkg::ERR_TRUNC;
        kind       = nend_pkg::KIND_ERROR;
        res.value  = '0;
        res.depth  = nest_depth_nxt;
      end
      ok = (failed_nxt == nend_pkg::ERR_NONE) && root_closed_nxt;
    end

    res.kind       = kind;
    res.error_code = (kind == nend_pkg::KIND_ERROR) ? failed_nxt : nend_pkg::ERR_NONE;
    res.file_ok    = ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_left_r    <= 3'(nend_pkg::HeaderLen);
      escape_pending_r <= 1'b0;
      expect_id_r      <= 1'b0;
      nest_depth_r     <= '0;
      root_closed_r    <= 1'b0;
      failed_r         <= nend_pkg::ERR_NONE;
    end else if (in_fire) begin
      header_left_r    <= header_left_nxt;
      escape_pending_r <= escape_pending_nxt;
      expect_id_r      <= expect_id_nxt;
      nest_depth_r     <= nest_depth_nxt;
      root_closed_r    <= root_closed_nxt;
      failed_r         <= failed_nxt;
    end
  end

  // result register plus one skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_item_r <= skid_item_r;
      end else if (in_fire) begin
        out_item_r <= res;
      end
    end else if (in_fire) begin
      skid_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // assertions
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while result register empty");

  a_err_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_item_r.error_code != nend_pkg::ERR_NONE) ==
                     (out_item_r.kind == nend_pkg::KIND_ERROR)))
    else $error("error code disagrees with event kind");

  a_ok_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.file_ok) |-> out_item_r.kind != nend_pkg::KIND_ERROR)
    else $error("file_ok on an error event");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nest_depth_r <= DW'(nend_pkg::MaxDepth))
    else $error("nesting depth beyond ceiling");

  a_held_on_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_fire) |=> skid_valid_r && $stable(skid_item_r))
    else $error("skid item lost while result stalled");

endmodule
